// ----- sv/pdc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pdc_pkg: shared constants of the prime and divisor-count classifier
// widths, table depth and the divider step counter width
// ----------------------------------------------------------------------------
package pdc_pkg;
  localparam int unsigned MaxPrimes = 8192;
  localparam int unsigned ValueBits = 16;
  localparam int unsigned AddrBits  = $clog2(MaxPrimes);
  localparam int unsigned CountBits = $clog2(MaxPrimes + 1);
  localparam int unsigned StepBits  = $clog2(ValueBits + 1);
endpackage
`default_nettype wire

// ----- sv/prime_and_divisor_count_classifier_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prime_and_divisor_count_classifier_top: trial-division classifier
// classifies candidates from 3 up as prime or composite and counts their divisors
// ----------------------------------------------------------------------------
// One beat in gives one beat out. Each candidate is divided by every stored
// prime in turn through one shared restoring divider that retires one
// quotient bit per cycle. A trial reads the table entry, loads the divider,
// shifts through all ValueBits quotient bits and checks the remainder; a
// trial that divides is repeated on the quotient for each further power. The
// work per item grows with the number of stored primes. The input is not
// ready while an item is in work or its result is still unread. The prime
// table has one read and one write port; only entries below the fill count
// are read, so it needs no clearing pass; entry zero reads as 2 from reset
// without being stored.
module prime_and_divisor_count_classifier_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [15:0] s_axis_tdata_i,   // [15:0] candidate
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o // [15:0] value [16] is_prime [24:17] divisor_count
                                     // [25] table_full [31:26] zero
);
  localparam int unsigned VB = pdc_pkg::ValueBits;
  localparam int unsigned AB = pdc_pkg::AddrBits;
  localparam int unsigned CB = pdc_pkg::CountBits;

  // sequencer codes
  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StRead = 3'd1;
  localparam logic [2:0] StLoad = 3'd2;
  localparam logic [2:0] StDiv  = 3'd3;
  localparam logic [2:0] StEval = 3'd4;
  localparam logic [2:0] StDone = 3'd5;
  localparam logic [2:0] StOut  = 3'd6;

  logic [2:0]    state_q, state_d;
  logic [VB-1:0] n_q;          // candidate
  logic [VB-1:0] q_q, q_d;     // running quotient of repeated division
  logic [VB-1:0] p_q;          // current prime
  logic [VB-1:0] dvd_q, dvd_d; // divider dividend / quotient shift reg
  logic [VB:0]   rem_q, rem_d; // divider partial remainder
  logic [pdc_pkg::StepBits-1:0] step_q, step_d;
  logic [CB-1:0] idx_q, idx_d, cnt_q, cnt_d;
  logic [7:0]    e_q, e_d, dc_q, dc_d;
  logic          div_q, div_d, full_q, full_d, prime_q, prime_d;

  // prime table
  logic [VB-1:0] mem_q [pdc_pkg::MaxPrimes];
  logic [VB-1:0] rd_q;
  logic [VB-1:0] p_rd;         // table entry, entry zero fixed at 2
  logic          wr_en;
  logic [AB-1:0] wr_addr, rd_addr;

  assign rd_addr = idx_q[AB-1:0];
  assign wr_addr = cnt_q[AB-1:0];
  assign p_rd    = (idx_q == '0) ? VB'(2) : rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= n_q;
    rd_q <= mem_q[rd_addr];
  end

  logic [VB:0]  trial;
  logic [15:0]  prod;
  assign trial = {rem_q[VB-1:0], dvd_q[VB-1]} - {1'b0, p_q};
  assign prod  = 16'(dc_q) * 16'(e_q + 8'd1);

  always_comb begin
    state_d = state_q; q_d = q_q; dvd_d = dvd_q; rem_d = rem_q; step_d = step_q;
    idx_d = idx_q; cnt_d = cnt_q; e_d = e_q; dc_d = dc_q; div_d = div_q;
    full_d = full_q; prime_d = prime_q; wr_en = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (s_axis_tvalid_i) begin
          dc_d = 8'd1; div_d = 1'b0; full_d = 1'b0; idx_d = '0; e_d = '0;
          q_d = s_axis_tdata_i[VB-1:0];
          if (s_axis_tdata_i[VB-1:0] < VB'(3)) begin
            dc_d = 8'd0; prime_d = 1'b0; state_d = StOut;
          end else state_d = StRead;
        end
      end
      StRead: state_d = StLoad;               // memory read latency
      StLoad: begin
        dvd_d = q_q; rem_d = '0; step_d = '0;
        state_d = (p_rd < VB'(2)) ? StEval : StDiv;
      end
      StDiv: begin
        // one restoring-division bit per cycle
        if (!trial[VB]) begin
          rem_d = trial; dvd_d = {dvd_q[VB-2:0], 1'b1};
        end else begin
          rem_d = {rem_q[VB-1:0], dvd_q[VB-1]}; dvd_d = {dvd_q[VB-2:0], 1'b0};
        end
        step_d = step_q + 1'b1;
        if (step_q == pdc_pkg::StepBits'(VB - 1)) state_d = StEval;
      end
      StEval: begin
        if (p_q >= VB'(2) && rem_q == '0) begin
          // divides: count the power and retry on the quotient
          q_d = dvd_q; e_d = e_q + 8'd1;
          dvd_d = dvd_q; rem_d = '0; step_d = '0; state_d = StDiv;
        end else begin
          if (e_q != 8'd0) begin
            div_d = 1'b1;
            dc_d = (prod > 16'd255) ? 8'd255 : prod[7:0];
          end
          e_d = '0; q_d = n_q; idx_d = idx_q + 1'b1;
          state_d = (idx_q + 1'b1 >= cnt_q) ? StDone : StRead;
        end
      end
      StDone: begin
        prime_d = !div_q;
        if (!div_q) begin
          dc_d = 8'd2;
          if (cnt_q < CB'(pdc_pkg::MaxPrimes)) begin
            wr_en = 1'b1; cnt_d = cnt_q + 1'b1;
          end else full_d = 1'b1;
        end
        state_d = StOut;
      end
      StOut: if (m_axis_tready_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; cnt_q <= CB'(1);
    end else begin
      state_q <= state_d; cnt_q <= cnt_d;
    end
  end

  // payload and working registers
  always_ff @(posedge clk_i) begin
    if (state_q == StIdle) n_q <= s_axis_tdata_i[VB-1:0];
    if (state_q == StLoad) p_q <= p_rd;
    q_q <= q_d; dvd_q <= dvd_d; rem_q <= rem_d; step_q <= step_d; idx_q <= idx_d;
    e_q <= e_d; dc_q <= dc_d; div_q <= div_d; full_q <= full_d; prime_q <= prime_d;
  end

  assign s_axis_tready_o = (state_q == StIdle);
  assign m_axis_tvalid_o = (state_q == StOut);
  assign m_axis_tdata_o  = {6'd0, full_q, dc_q, prime_q, n_q};

  // a prime result always counts two divisors
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o[16]) |-> m_axis_tdata_o[24:17] == 8'd2)
    else $error("prime without two divisors");
  // full flag only with a prime
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o[25]) |-> m_axis_tdata_o[16])
    else $error("table full on composite");
  // fill count never drops to zero or beyond the depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != '0 && cnt_q <= CB'(pdc_pkg::MaxPrimes))
    else $error("fill count out of range");
endmodule
`default_nettype wire
